// File: sv/stip_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the string-to-integer parser.
// Holds character codes, the character class word and the parser phase codes.
package stip_pkg;

    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 6;
    localparam int DIGIT_W      = 6;
    localparam int VALUE_W      = 32;
    localparam int OUT_OFFSET_W = 16;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    // Offsets that turn letters into digit values 10 to 35.
    localparam logic [CHAR_W-1:0] CH_UA_M10 = 8'h37;
    localparam logic [CHAR_W-1:0] CH_LA_M10 = 8'h57;

    // Radix codes.
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // Magnitude limits for positive and negative results.
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Register index taken from paddr[2].
    localparam logic [0:0] REG_NUMBER_BASE = 1'b0;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_SOME,
        ST_OVER
    } dstat_t;

    typedef struct packed {
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               is_alnum;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

    localparam int CLASS_W = $bits(char_class_t);

endpackage

// File: sv/stip_front.sv
`timescale 1ns / 1ps
// Front end of the parser: accepts characters and classifies each one.
// Depends on stip_pkg; pushes the class word into stip_queue.
module stip_front (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               character,
    input  logic                     q_full,
    output logic                     q_push,
    output stip_pkg::char_class_t    q_word
);
    import stip_pkg::*;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_word          = '0;
        q_word.is_space = (character == CH_SPACE);
        q_word.is_minus = (character == CH_MINUS);
        q_word.is_plus  = (character == CH_PLUS);
        q_word.is_zero  = (character == CH_ZERO);
        q_word.is_x     = (character == CH_LX) || (character == CH_UX);
        if (character >= CH_ZERO && character <= CH_NINE)
        begin
            q_word.is_alnum = 1'b1;
            q_word.digit    = DIGIT_W'(character - CH_ZERO);
        end
        else if (character >= CH_UA && character <= CH_UZ)
        begin
            q_word.is_alnum = 1'b1;
            q_word.digit    = DIGIT_W'(character - CH_UA_M10);
        end
        else if (character >= CH_LA && character <= CH_LZ)
        begin
            q_word.is_alnum = 1'b1;
            q_word.digit    = DIGIT_W'(character - CH_LA_M10);
        end
    end

endmodule

// File: sv/stip_queue.sv
`timescale 1ns / 1ps
// Small flip-flop queue that decouples the front end from the parser core.
// Stand-alone; no package needed.
module stip_queue #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/stip_back.sv
`timescale 1ns / 1ps
// Parser core: runs the sign, prefix and digit state machine on class words
// and holds the result word in an output register. Depends on stip_pkg.
module stip_back #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [stip_pkg::BASE_W-1:0]           cfg_base,
    input  logic                                  q_valid,
    input  stip_pkg::char_class_t                 q_word,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [stip_pkg::VALUE_W-1:0]   value,
    output logic [stip_pkg::OUT_OFFSET_W-1:0]     end_offset,
    output logic                                  overflowed,
    output logic                                  digits_found
);
    import stip_pkg::*;

    localparam int PROD_W = VALUE_W + BASE_W + 1;

    phase_t                   phase_reg, phase_next;
    dstat_t                   status_reg, status_next;
    logic                     neg_reg, neg_next;
    logic [VALUE_W-1:0]       acc_reg, acc_next;
    logic [BASE_W-1:0]        abase_reg, abase_next;
    logic [OFFSET_WIDTH-1:0]  pos_reg, pos_next;
    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]       value_reg;
    logic [OUT_OFFSET_W-1:0]  end_offset_reg;
    logic                     overflowed_reg, digits_found_reg;

    logic                     step, first_char, fc_prefix, do_feed, digit_ok, too_big, emit;
    logic [BASE_W-1:0]        fc_base, eff_base;
    dstat_t                   stat_in;
    logic [VALUE_W-1:0]       acc_in, limit, result_value;
    logic [PROD_W-1:0]        prod;
    logic [OUT_OFFSET_W-1:0]  pos16;

    generate
        if (OFFSET_WIDTH >= OUT_OFFSET_W)
        begin : g_pos_trunc
            assign pos16 = pos_reg[OUT_OFFSET_W-1:0];
        end
        else
        begin : g_pos_ext
            assign pos16 = {{(OUT_OFFSET_W - OFFSET_WIDTH){1'b0}}, pos_reg};
        end
    endgenerate

    // A word is taken whenever the output register is free or being emptied.
    assign step  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = step;

    assign fc_prefix = ((cfg_base == BASE_AUTO) || (cfg_base == BASE_HEX)) && q_word.is_zero;
    assign fc_base   = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;

    // Select the base, status and accumulator that a digit is fed against.
    always_comb
    begin
        first_char = 1'b0;
        do_feed    = 1'b0;
        eff_base   = abase_reg;
        stat_in    = status_reg;
        acc_in     = acc_reg;
        unique case (phase_reg)
            PH_SKIP:
            begin
                first_char = !(q_word.is_space || q_word.is_minus || q_word.is_plus);
            end
            PH_SIGNED:
            begin
                first_char = 1'b1;
            end
            PH_ZERO:
            begin
                if (!q_word.is_x)
                begin
                    do_feed  = 1'b1;
                    eff_base = (abase_reg == BASE_HEX) ? BASE_HEX : BASE_OCT;
                    stat_in  = ST_SOME;
                    acc_in   = '0;
                end
            end
            PH_DIGITS:
            begin
                do_feed = 1'b1;
            end
            default:
            begin
                do_feed = 1'b0;
            end
        endcase
        if (first_char && !fc_prefix)
        begin
            do_feed  = 1'b1;
            eff_base = fc_base;
        end
    end

    assign digit_ok = q_word.is_alnum && (q_word.digit < eff_base);
    assign prod     = PROD_W'(acc_in) * PROD_W'(eff_base) + PROD_W'(q_word.digit);
    assign limit    = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign too_big  = prod > PROD_W'(limit);
    assign emit     = step && do_feed && !digit_ok;

    // Phase transitions.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (q_word.is_space)
                        phase_next = PH_SKIP;
                    else if (q_word.is_minus || q_word.is_plus)
                        phase_next = PH_SIGNED;
                    else if (fc_prefix)
                        phase_next = PH_ZERO;
                    else
                        phase_next = digit_ok ? PH_DIGITS : PH_SKIP;
                end
                PH_SIGNED:
                begin
                    if (fc_prefix)
                        phase_next = PH_ZERO;
                    else
                        phase_next = digit_ok ? PH_DIGITS : PH_SKIP;
                end
                PH_ZERO:
                begin
                    if (q_word.is_x)
                        phase_next = PH_DIGITS;
                    else
                        phase_next = digit_ok ? PH_DIGITS : PH_SKIP;
                end
                PH_DIGITS:
                begin
                    phase_next = digit_ok ? PH_DIGITS : PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    // Datapath and result updates.
    always_comb
    begin
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        status_next    = status_reg;
        abase_next     = abase_reg;
        pos_next       = pos_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (stat_in == ST_OVER)
            result_value = neg_reg ? NEG_LIMIT : POS_LIMIT;
        else
            result_value = neg_reg ? (VALUE_W'(0) - acc_in) : acc_in;
        if (step)
        begin
            if (emit)
            begin
                out_valid_next = 1'b1;
                neg_next       = 1'b0;
                acc_next       = '0;
                status_next    = ST_NONE;
                abase_next     = '0;
                pos_next       = '0;
            end
            else
            begin
                if (pos_reg != {OFFSET_WIDTH{1'b1}})
                    pos_next = pos_reg + OFFSET_WIDTH'(1);
                if (phase_reg == PH_SKIP && q_word.is_minus)
                    neg_next = 1'b1;
                if (first_char)
                    abase_next = fc_prefix ? cfg_base : fc_base;
                if (phase_reg == PH_ZERO)
                    abase_next = q_word.is_x ? BASE_HEX : eff_base;
                if (do_feed)
                begin
                    if (stat_in == ST_OVER || too_big)
                    begin
                        status_next = ST_OVER;
                        acc_next    = acc_in;
                    end
                    else
                    begin
                        status_next = ST_SOME;
                        acc_next    = prod[VALUE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            status_reg    <= ST_NONE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            abase_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            status_reg    <= status_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            abase_reg     <= abase_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg        <= result_value;
            digits_found_reg <= (stat_in != ST_NONE);
            overflowed_reg   <= (stat_in == ST_OVER);
            end_offset_reg   <= (stat_in != ST_NONE) ? pos16 : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = signed'(value_reg);
    assign end_offset   = end_offset_reg;
    assign overflowed   = overflowed_reg;
    assign digits_found = digits_found_reg;

endmodule

// File: sv/string_to_integer_parser_unit.sv
`timescale 1ns / 1ps
// Streaming strtol-style parser, one character per word, 32-bit signed result.
// Throughput: one character per cycle while the output register is free or being
// emptied, set by the single multiply-add and limit compare in the parser core.
// A terminating character is queued and its result word is then registered in the
// output register. Reset clears the queue, the parser state and the base (0).
module string_to_integer_parser_unit #(
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Character channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [stip_pkg::CHAR_W-1:0]           character,
    // Result channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [stip_pkg::VALUE_W-1:0]   value,
    output logic [stip_pkg::OUT_OFFSET_W-1:0]     end_offset,
    output logic                                  overflowed,
    output logic                                  digits_found,
    // APB-style configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import stip_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic [BASE_W-1:0]  base_reg, base_next;
    logic               cfg_write;
    logic               q_push, q_full, q_pop, q_valid;
    char_class_t        push_word, head_word;
    logic [CLASS_W-1:0] head_bits;

    // The configuration register. Writes take effect in the access phase;
    // the port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_NUMBER_BASE);
    assign base_next = cfg_write ? pwdata[BASE_W-1:0] : base_reg;
    assign prdata    = (paddr[2] == REG_NUMBER_BASE) ? {{(32 - BASE_W){1'b0}}, base_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_AUTO;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    // The front end classifies each character as it is accepted, so the core
    // only compares small flags and a six-bit digit value.
    stip_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_word    (push_word)
    );

    // The queue lets the input side keep accepting words while a result word
    // waits in the core's output register.
    stip_queue #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_bits),
        .not_empty (q_valid)
    );

    assign head_word = char_class_t'(head_bits);

    // The core samples the base when a string's radix is resolved; the user must see
    // that the base only changes while the block is idle; the block does not enforce it.
    stip_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_base     (base_reg),
        .q_valid      (q_valid),
        .q_word       (head_word),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .end_offset   (end_offset),
        .overflowed   (overflowed),
        .digits_found (digits_found)
    );

    // A result without digits carries all-zero fields.
    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !digits_found) |-> (value == 0 && end_offset == 0 && !overflowed))
        else $error("result without digits has nonzero fields");

    // An overflowed result is saturated and counts as having digits.
    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflowed) |->
            (digits_found && (value == 32'sh7FFF_FFFF || value == 32'sh8000_0000)))
        else $error("overflowed result is not saturated");

    // A write to the base register takes effect at the next edge.
    a_base_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (base_reg == $past(pwdata[BASE_W-1:0])))
        else $error("base register write lost");

endmodule

// File: verif/string_to_integer_parser_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for string_to_integer_parser_unit.
// Needs stip_pkg and the parser RTL; it predicts every result word on its own.
module string_to_integer_parser_unit_tb;
    import stip_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 2000;
    // Cycles allowed for characters still inside the block to drain.
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 50;
    localparam int MODE_CHARS    = 635;

    localparam logic [2:0]        BASE_REG_ADDR = {REG_NUMBER_BASE, 2'b00};
    localparam logic [6:0]        NOT_A_DIGIT   = 7'd64;
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TOP        = 8'hFF;
    localparam logic [BASE_W-1:0] BASE_ONE      = 6'd1;
    localparam logic [BASE_W-1:0] BASE_TOP      = 6'd63;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [OUT_OFFSET_W-1:0]   end_offset;
        logic                      overflowed;
        logic                      digits_found;
    } number_word_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [CHAR_W-1:0]           character = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [VALUE_W-1:0]   value;
    logic [OUT_OFFSET_W-1:0]     end_offset;
    logic                        overflowed;
    logic                        digits_found;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [2:0]                  paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Predictor copy of the parser state and its base register.
    logic [BASE_W-1:0]           base_setting = BASE_AUTO;
    phase_t                      cur_phase    = PH_SKIP;
    logic                        sign_neg     = 1'b0;
    logic [VALUE_W-1:0]          magnitude    = '0;
    dstat_t                      digit_state  = ST_NONE;
    logic [BASE_W-1:0]           radix        = '0;
    logic [OUT_OFFSET_W-1:0]     char_index   = '0;

    number_word_t                expected_numbers[$];
    logic [CHAR_W-1:0]           pending_chars[$];
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    int                          error_count   = 0;
    int unsigned                 chars_queued  = 0;

    string_to_integer_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .character    (character),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .end_offset   (end_offset),
        .overflowed   (overflowed),
        .digits_found (digits_found),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Value of a digit or letter; anything else never passes a radix test.
    function automatic logic [6:0] digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ) return 7'(c - CH_UA_M10);
        if (c >= CH_LA && c <= CH_LZ) return 7'(c - CH_LA_M10);
        return NOT_A_DIGIT;
    endfunction

    // Folds c into the magnitude. Returns 0 when c is not a digit of the radix.
    // Once saturated, digits are still swallowed but the magnitude is frozen.
    function automatic bit add_digit(input logic [CHAR_W-1:0] c);
        logic [6:0]         d;
        logic [63:0]        sum;
        logic [VALUE_W-1:0] limit;
        d = digit_value(c);
        if (d >= {1'b0, radix}) return 1'b0;
        if (digit_state == ST_OVER) return 1'b1;
        limit = sign_neg ? NEG_LIMIT : POS_LIMIT;
        sum = 64'(magnitude) * 64'(radix) + 64'(d);
        if (sum > 64'(limit))
        begin
            digit_state = ST_OVER;
        end
        else
        begin
            magnitude   = sum[VALUE_W-1:0];
            digit_state = ST_SOME;
        end
        return 1'b1;
    endfunction

    // The number is over: queue its result word and start a new string.
    function automatic void emit_number();
        number_word_t w;
        if (digit_state == ST_OVER)
            w.value = sign_neg ? NEG_LIMIT : POS_LIMIT;
        else
            w.value = sign_neg ? -magnitude : magnitude;
        w.end_offset   = (digit_state != ST_NONE) ? char_index : '0;
        w.overflowed   = (digit_state == ST_OVER);
        w.digits_found = (digit_state != ST_NONE);
        expected_numbers.push_back(w);
        cur_phase   = PH_SKIP;
        sign_neg    = 1'b0;
        magnitude   = '0;
        digit_state = ST_NONE;
        radix       = '0;
        char_index  = '0;
    endfunction

    // First character after spaces and sign: this is where the base register
    // is sampled. A leading zero under auto or hex waits for a possible x.
    function automatic bit resolve_radix(input logic [CHAR_W-1:0] c);
        if ((base_setting == BASE_AUTO || base_setting == BASE_HEX) && c == CH_ZERO)
        begin
            radix     = base_setting;
            cur_phase = PH_ZERO;
            return 1'b0;
        end
        radix     = (base_setting == BASE_AUTO) ? BASE_DEC : base_setting;
        cur_phase = PH_DIGITS;
        if (add_digit(c)) return 1'b0;
        emit_number();
        return 1'b1;
    endfunction

    function automatic void track_char(input logic [CHAR_W-1:0] c);
        bit done;
        done = 1'b0;
        case (cur_phase)
            PH_SIGNED: done = resolve_radix(c);
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    radix     = BASE_HEX;
                    cur_phase = PH_DIGITS;
                end
                else
                begin
                    // The zero itself counts as a digit of an octal or hex number.
                    radix       = (radix == BASE_HEX) ? BASE_HEX : BASE_OCT;
                    digit_state = ST_SOME;
                    magnitude   = '0;
                    cur_phase   = PH_DIGITS;
                    if (!add_digit(c))
                    begin
                        emit_number();
                        done = 1'b1;
                    end
                end
            end
            PH_DIGITS:
            begin
                if (!add_digit(c))
                begin
                    emit_number();
                    done = 1'b1;
                end
            end
            default:
            begin
                if (c == CH_SPACE)
                begin
                    cur_phase = PH_SKIP;
                end
                else if (c == CH_MINUS)
                begin
                    sign_neg  = 1'b1;
                    cur_phase = PH_SIGNED;
                end
                else if (c == CH_PLUS)
                begin
                    cur_phase = PH_SIGNED;
                end
                else
                begin
                    done = resolve_radix(c);
                end
            end
        endcase
        // The offset counter saturates rather than wrapping.
        if (!done && char_index != '1) char_index++;
    endfunction

    // ------------------------------------------------------------------
    // Character driver: takes words from pending_chars, predicts on acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready) track_char(character);
            if (!in_valid || in_ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    character <= pending_chars.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted word is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        number_word_t got;
        number_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{value, end_offset, overflowed, digits_found};
                if (expected_numbers.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display({"%0t: unexpected result word value=%0d offset=%0d ",
                                  "ovf=%0b found=%0b"},
                                 $time, got.value, got.end_offset, got.overflowed,
                                 got.digits_found);
                    error_count++;
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    if (got !== want)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display({"%0t: mismatch expected value=%0d offset=%0d ovf=%0b ",
                                      "found=%0b, actual value=%0d offset=%0d ovf=%0b found=%0b"},
                                     $time, want.value, want.end_offset, want.overflowed,
                                     want.digits_found, got.value, got.end_offset,
                                     got.overflowed, got.digits_found);
                        error_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Ends the run when neither channel has moved a word for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endtask

    // Character for digit value v, letters in either case.
    function automatic logic [CHAR_W-1:0] make_digit(input int unsigned v);
        if (v < 10) return CHAR_W'(CH_ZERO + v);
        return CHAR_W'(($urandom_range(1) ? CH_UA_M10 : CH_LA_M10) + v);
    endfunction

    // Waits until the block holds no work, so that the base may be rewritten.
    task automatic settle();
        while (pending_chars.size() != 0 || in_valid || expected_numbers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the base register, then reads it back through the same port.
    task automatic write_number_base(input logic [BASE_W-1:0] b);
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= BASE_REG_ADDR;
        pwdata <= 32'(b);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        base_setting = b;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(b))
        begin
            if (error_count < MAX_REPORTS)
                $display("%0t: base readback expected %0d actual %0d", $time, b, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(11))
            0, 1:    return BASE_AUTO;
            2:       return BASE_ONE;
            3:       return BASE_W'(2);
            4:       return BASE_OCT;
            5:       return BASE_DEC;
            6, 7:    return BASE_HEX;
            8:       return BASE_W'(36);
            9:       return BASE_TOP;
            default: return BASE_W'($urandom_range(63));
        endcase
    endfunction

    // One well-formed number for the current base: optional spaces and sign,
    // optional 0 / 0x prefix, digits of the base, then some terminator.
    task automatic push_number();
        int unsigned eff;
        int unsigned ndig;
        repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0) queue_char(CH_SPACE);
        case ($urandom_range(2))
            0:       queue_char(CH_MINUS);
            1:       queue_char(CH_PLUS);
            default: ;
        endcase
        eff = (base_setting == BASE_AUTO) ? 10 : (base_setting > 36 ? 36 : base_setting);
        if ((base_setting == BASE_AUTO || base_setting == BASE_HEX)
            && $urandom_range(2) == 0)
        begin
            queue_char(CH_ZERO);
            if ($urandom_range(3) != 0)
            begin
                queue_char($urandom_range(1) ? CH_LX : CH_UX);
                eff = 16;
            end
            else if (base_setting == BASE_AUTO)
            begin
                eff = 8;
            end
        end
        // Now and then a value near the 32-bit limit.
        if (eff == 10 && $urandom_range(5) == 0)
        begin
            queue_text("214748364");
            queue_char(CHAR_W'(CH_ZERO + $urandom_range(9, 6)));
        end
        else if (eff == 16 && $urandom_range(5) == 0)
        begin
            if ($urandom_range(1))
                queue_text("7fffffff");
            else
                queue_text("80000000");
        end
        else
        begin
            ndig = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 0);
            repeat (ndig) queue_char(make_digit($urandom_range(eff - 1)));
        end
        case ($urandom_range(3))
            0:       queue_char(CH_SPACE);
            1:       queue_char(CH_NUL);
            2:       queue_char(CHAR_W'($urandom_range(255)));
            default: queue_char(eff < 36 ? make_digit($urandom_range(35, eff)) : CH_SPACE);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned seg_end;
        int unsigned mode_end;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 51;

        // Auto base from reset: a bare hex prefix, a signed octal value and no digits.
        queue_text("0x!");
        queue_text("-017 ");
        queue_text("z");
        settle();
        // Base one knows only the zero digit; the top code ends the word.
        write_number_base(BASE_ONE);
        queue_text("00");
        queue_char(CH_TOP);
        settle();
        // Widest base: every letter is a digit, and six of them overflow negative.
        write_number_base(BASE_TOP);
        queue_text("-zzzzzz");
        queue_char(CH_NUL);
        // A sign under one base, the digits after a switch to hex.
        queue_char(CH_PLUS);
        settle();
        write_number_base(BASE_HEX);
        queue_text("Ff.");

        // Random numbers under three idling patterns, the base changing between segments.
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mode_end = chars_queued + MODE_CHARS;
            while (chars_queued < mode_end)
            begin
                settle();
                write_number_base(pick_base());
                seg_end = chars_queued + $urandom_range(160, 60);
                while (chars_queued < seg_end)
                begin
                    if ($urandom_range(5) == 0)
                        repeat ($urandom_range(4, 1)) queue_char(CHAR_W'($urandom_range(255)));
                    else
                        push_number();
                end
            end
        end

        settle();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
sv/stip_pkg.sv
sv/stip_front.sv
sv/stip_queue.sv
sv/stip_back.sv
sv/string_to_integer_parser_unit.sv
verif/string_to_integer_parser_unit_tb.sv
